// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define CCG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define CCG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ccg_pkg.sv -----
// ----------------------------------------------------------------------------
// ccg_pkg
// Shared types, constants and tables of the chord endpoint generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccg_pkg;

  localparam int INDEX_BITS    = 18;
  localparam int CORDIC_STAGES = 16;
  localparam int STAGE_W       = $clog2(CORDIC_STAGES + 1);
  localparam int TURN_W        = 32;
  localparam int VEC_W         = 34;
  localparam int COORD_W       = 18;
  localparam int TPP_W         = 31;
  localparam int MULT_W        = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_DATA_W     = ((INDEX_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W    = 4 * COORD_W;

  localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [TURN_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic signed [VEC_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURN_PER_POINT = 3'd0,
    CFG_MULTIPLIER     = 3'd1,
    CFG_CENTER_X       = 3'd2,
    CFG_CENTER_Y       = 3'd3,
    CFG_RADIUS         = 3'd4,
    CFG_HIGHLIGHT      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
    logic                    flip;
  } cell_t;

  // atan(2^-i) as a Q0.32 turn
  function automatic logic signed [VEC_W-1:0] atan_at(input logic [STAGE_W-1:0] i);
    logic signed [VEC_W-1:0] a;
    case (i)
      5'd0:    a = 34'sd536870912;
      5'd1:    a = 34'sd316933406;
      5'd2:    a = 34'sd167458907;
      5'd3:    a = 34'sd85004756;
      5'd4:    a = 34'sd42667331;
      5'd5:    a = 34'sd21354465;
      5'd6:    a = 34'sd10679838;
      5'd7:    a = 34'sd5340245;
      5'd8:    a = 34'sd2670163;
      5'd9:    a = 34'sd1335087;
      5'd10:   a = 34'sd667544;
      5'd11:   a = 34'sd333772;
      5'd12:   a = 34'sd166886;
      5'd13:   a = 34'sd83443;
      5'd14:   a = 34'sd41722;
      5'd15:   a = 34'sd20861;
      5'd16:   a = 34'sd10430;
      5'd17:   a = 34'sd5215;
      5'd18:   a = 34'sd2608;
      5'd19:   a = 34'sd1304;
      5'd20:   a = 34'sd652;
      5'd21:   a = 34'sd326;
      5'd22:   a = 34'sd163;
      5'd23:   a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Rotate the start to the top, fold the left half plane onto the right
  function automatic cell_t cordic_init(input logic [TURN_W-1:0] turn);
    logic [TURN_W-1:0] t;
    cell_t c;
    t      = turn - QUARTER_TURN;
    c.flip = t[TURN_W-1] ^ t[TURN_W-2];
    if (c.flip) begin
      t = t ^ HALF_TURN;
    end
    c.z = VEC_W'(signed'(t));
    c.x = INV_GAIN_Q30;
    c.y = '0;
    return c;
  endfunction

endpackage

// ----- rtl/ccg_turn.sv -----
// ----------------------------------------------------------------------------
// ccg_turn
// Two-stage multiply pipeline: source and destination turns of an index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccg_turn (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ccg_pkg::INDEX_BITS-1:0]    idx,
  input  logic [ccg_pkg::TPP_W-1:0]         turn_per_point,
  input  logic [ccg_pkg::MULT_W-1:0]        multiplier_q16,
  output logic [ccg_pkg::TURN_W-1:0]        src_turn,
  output logic [ccg_pkg::TURN_W-1:0]        dst_turn
);
  import ccg_pkg::*;

  localparam int P_W = 48;
  localparam int H_W = 24;

  logic [TURN_W-1:0] src_a_r, src_b_r;
  logic [P_W-1:0]    p_a_r;
  logic [H_W+TPP_W-1:0] lo_b_r;
  logic [H_W-1:0]    hi_b_r;
  logic [INDEX_BITS+TPP_W-1:0] src_full;
  logic [MULT_W+INDEX_BITS-1:0] p_full;
  logic [H_W+TPP_W-1:0] hi_full;
  logic [P_W+7:0]    sum;

  assign src_full = idx * turn_per_point;
  assign p_full   = multiplier_q16 * idx;
  assign hi_full  = p_a_r[P_W-1:H_W] * turn_per_point;

  always_ff @(posedge clk) begin
    if (en) begin
      src_a_r <= src_full[TURN_W-1:0];
      p_a_r   <= p_full[P_W-1:0];
      src_b_r <= src_a_r;
      lo_b_r  <= p_a_r[H_W-1:0] * turn_per_point;
      hi_b_r  <= hi_full[H_W-1:0];
    end
  end

  // product mod 2^48, then drop the 16 fraction bits of the multiplier
  assign sum      = {1'b0, lo_b_r} + {8'd0, hi_b_r, {H_W{1'b0}}};
  assign dst_turn = sum[P_W-1:16];
  assign src_turn = src_b_r;

endmodule

// ----- rtl/ccg_cell.sv -----
// ----------------------------------------------------------------------------
// ccg_cell
// One CORDIC rotation cell; registers its vector and residual angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccg_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ccg_pkg::STAGE_W-1:0]   stage,
  input  ccg_pkg::cell_t                d,
  output ccg_pkg::cell_t                q
);
  import ccg_pkg::*;

  cell_t q_r, q_nxt;
  logic signed [VEC_W-1:0] dx, dy, a;

  always_comb begin
    dx = d.y >>> stage;
    dy = d.x >>> stage;
    a  = atan_at(stage);
    q_nxt.flip = d.flip;
    if (!d.z[VEC_W-1]) begin
      q_nxt.x = d.x - dx;
      q_nxt.y = d.y + dy;
      q_nxt.z = d.z - a;
    end else begin
      q_nxt.x = d.x + dx;
      q_nxt.y = d.y - dy;
      q_nxt.z = d.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ----- rtl/ccg_place.sv -----
// ----------------------------------------------------------------------------
// ccg_place
// Scales a unit coordinate by the radius, rounds, adds the center, saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccg_place (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ccg_pkg::VEC_W-1:0]  unit,
  input  logic [ccg_pkg::COORD_W-1:0]       radius,
  input  logic [ccg_pkg::COORD_W-1:0]       center,
  output logic [ccg_pkg::COORD_W-1:0]       coord
);
  import ccg_pkg::*;

  localparam int PROD_W = COORD_W + 1 + VEC_W;
  localparam int SH_W   = PROD_W - 30;
  localparam int V_W    = SH_W + 2;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rnd;
  logic signed [V_W-1:0]    v;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= $signed({1'b0, radius}) * unit;
    end
  end

  // the scaled offset is signed; keep its sign when widening
  always_comb begin
    rnd = prod_r + (PROD_W'(1) <<< 29);
    v   = V_W'(signed'(rnd[PROD_W-1:30])) + $signed({{(V_W-COORD_W){1'b0}}, center});
    if (v[V_W-1]) begin
      coord = '0;
    end else if (v > $signed({{(V_W-COORD_W){1'b0}}, {COORD_W{1'b1}}})) begin
      coord = '1;
    end else begin
      coord = v[COORD_W-1:0];
    end
  end

endmodule

// ----- rtl/modular_chord_endpoint_generator.sv -----
// Pipeline: 2 multiply stages, 16 CORDIC cells, 1 radius multiply stage and
//   1 output register between input transaction and result.
// Throughput: one index per cycle; the whole pipeline stalls only while a
//   result waits at the output and out_tready is low.
// Reset: synchronous active-low rst_n clears valid flags and reloads the
//   configuration registers with their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// modular_chord_endpoint_generator
// Chord endpoints of a modular times table on a circle, CORDIC cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_chord_endpoint_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ccg_pkg::IN_DATA_W-1:0]       in_tdata,   // point index
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ccg_pkg::OUT_DATA_W-1:0]      out_tdata,  // src_x, src_y, dst_x, dst_y
  output logic                                out_tuser,  // is_highlighted
  input  logic                                cfg_wr_en,
  input  logic [ccg_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [ccg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ccg_pkg::*;

  localparam int DEPTH = 2 + CORDIC_STAGES + 2;

  logic [TPP_W-1:0]      tpp_r;
  logic [MULT_W-1:0]     mult_r;
  logic [COORD_W-1:0]    cx_r, cy_r, rad_r;
  logic [INDEX_BITS:0]   hl_r;

  logic                  en, accept, hit;
  logic [DEPTH-1:0]      vld_r, flag_r;
  logic [INDEX_BITS-1:0] idx;
  logic [TURN_W-1:0]     src_turn, dst_turn;
  cell_t                 sc [CORDIC_STAGES+1];
  cell_t                 dc [CORDIC_STAGES+1];
  logic signed [VEC_W-1:0] sx, sy, dx, dy;
  logic [COORD_W-1:0]    psx, psy, pdx, pdy;
  logic [OUT_DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r  <= TPP_W'(11930464);
      mult_r <= MULT_W'(131072);
      cx_r   <= COORD_W'(17280);
      cy_r   <= COORD_W'(17280);
      rad_r  <= COORD_W'(15898);
      hl_r   <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_TURN_PER_POINT: tpp_r  <= cfg_wdata[TPP_W-1:0];
        CFG_MULTIPLIER:     mult_r <= cfg_wdata[MULT_W-1:0];
        CFG_CENTER_X:       cx_r   <= cfg_wdata[COORD_W-1:0];
        CFG_CENTER_Y:       cy_r   <= cfg_wdata[COORD_W-1:0];
        CFG_RADIUS:         rad_r  <= cfg_wdata[COORD_W-1:0];
        CFG_HIGHLIGHT:      hl_r   <= cfg_wdata[INDEX_BITS:0];
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;
  assign idx       = in_tdata[INDEX_BITS-1:0];
  assign hit       = !hl_r[INDEX_BITS] && (hl_r[INDEX_BITS-1:0] == idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag_r <= {flag_r[DEPTH-2:0], hit};
    end
  end

  ccg_turn u_turn (
    .clk            (clk),
    .en             (en),
    .idx            (idx),
    .turn_per_point (tpp_r),
    .multiplier_q16 (mult_r),
    .src_turn       (src_turn),
    .dst_turn       (dst_turn)
  );

  assign sc[0] = cordic_init(src_turn);
  assign dc[0] = cordic_init(dst_turn);

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cells
    ccg_cell u_src_cell (
      .clk   (clk),
      .en    (en),
      .stage (STAGE_W'(g)),
      .d     (sc[g]),
      .q     (sc[g+1])
    );
    ccg_cell u_dst_cell (
      .clk   (clk),
      .en    (en),
      .stage (STAGE_W'(g)),
      .d     (dc[g]),
      .q     (dc[g+1])
    );
  end

  assign sx = sc[CORDIC_STAGES].flip ? -sc[CORDIC_STAGES].x : sc[CORDIC_STAGES].x;
  assign sy = sc[CORDIC_STAGES].flip ? -sc[CORDIC_STAGES].y : sc[CORDIC_STAGES].y;
  assign dx = dc[CORDIC_STAGES].flip ? -dc[CORDIC_STAGES].x : dc[CORDIC_STAGES].x;
  assign dy = dc[CORDIC_STAGES].flip ? -dc[CORDIC_STAGES].y : dc[CORDIC_STAGES].y;

  ccg_place u_place_sx (.clk(clk), .en(en), .unit(sx), .radius(rad_r), .center(cx_r),
                        .coord(psx));
  ccg_place u_place_sy (.clk(clk), .en(en), .unit(sy), .radius(rad_r), .center(cy_r),
                        .coord(psy));
  ccg_place u_place_dx (.clk(clk), .en(en), .unit(dx), .radius(rad_r), .center(cx_r),
                        .coord(pdx));
  ccg_place u_place_dy (.clk(clk), .en(en), .unit(dy), .radius(rad_r), .center(cy_r),
                        .coord(pdy));

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= {pdy, pdx, psy, psx};
    end
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = data_r;
  assign out_tuser  = flag_r[DEPTH-1];

endmodule

// ----- rtl/ccg_checker.sv -----
// ----------------------------------------------------------------------------
// ccg_port_checks
// Port-level checks of the chord endpoint generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccg_port_checks (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [ccg_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                out_tuser
);
  import ccg_pkg::*;

  `CCG_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `CCG_ASSERT_NXT(a_data_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `CCG_ASSERT_IMP(a_ready, clk, rst_n, 1'b1, in_tready == (!out_tvalid || out_tready), "ready not tied to output space")
  `CCG_ASSERT_IMP(a_reset_empty, clk, rst_n, $past(!rst_n), !out_tvalid, "result after reset")

endmodule

bind modular_chord_endpoint_generator ccg_port_checks u_ccg_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/ccg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccg_checker
// Watches the index and endpoint streams and the register port. Each accepted
// index is run through a bit-exact chord endpoint model and queued. Each
// returned endpoint pair is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------

module ccg_checker
  import ccg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output logic                  active
);

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic               hl;
  } chord_t;

  localparam longint ARCTAN_TURN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  logic [TPP_W-1:0]          tpp;
  logic [MULT_W-1:0]         mult;
  logic [COORD_W-1:0]        cx, cy, rad;
  logic signed [INDEX_BITS:0] hl_idx;

  chord_t chord_q[$];

  assign pending = chord_q.size();

  // screen coordinate along one axis, saturated
  function automatic logic [COORD_W-1:0] axis_coord(logic [COORD_W-1:0] ctr, longint unit);
    longint v;
    v = longint'(ctr) + ((longint'(rad) * unit + (longint'(1) << 29)) >>> 30);
    if (v < 0) return '0;
    if (v > 262143) return '1;
    return v[COORD_W-1:0];
  endfunction

  function automatic void endpoint_xy(logic [31:0] turn, output logic [COORD_W-1:0] px,
                                      output logic [COORD_W-1:0] py);
    logic [31:0] t;
    logic        flip;
    longint      x, y, z, dx, dy;
    t    = turn - QUARTER_TURN;
    flip = t[31] ^ t[30];
    if (flip) t = t ^ HALF_TURN;
    z = longint'(signed'(t));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARCTAN_TURN[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARCTAN_TURN[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    px = axis_coord(cx, x);
    py = axis_coord(cy, y);
  endfunction

  function automatic chord_t chord_of(logic [INDEX_BITS-1:0] idx);
    chord_t      c;
    logic [63:0] src_prod;
    logic [47:0] p;
    logic [95:0] dst_prod;
    src_prod = 64'(idx) * 64'(tpp);
    p        = 48'(64'(mult) * 64'(idx));
    dst_prod = 96'(p) * 96'(tpp);
    endpoint_xy(src_prod[31:0], c.src_x, c.src_y);
    endpoint_xy(dst_prod[47:16], c.dst_x, c.dst_y);
    c.hl = (hl_idx >= 0) && (hl_idx[INDEX_BITS-1:0] == idx);
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    chord_t exp_c;
    active <= (in_tvalid && in_tready) || (out_tvalid && out_tready);
    if (!rst_n) begin
      tpp    <= 31'd11930464;
      mult   <= 32'd131072;
      cx     <= 18'd17280;
      cy     <= 18'd17280;
      rad    <= 18'd15898;
      hl_idx <= '1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_addr))
          CFG_TURN_PER_POINT: tpp    <= cfg_wdata[TPP_W-1:0];
          CFG_MULTIPLIER:     mult   <= cfg_wdata;
          CFG_CENTER_X:       cx     <= cfg_wdata[COORD_W-1:0];
          CFG_CENTER_Y:       cy     <= cfg_wdata[COORD_W-1:0];
          CFG_RADIUS:         rad    <= cfg_wdata[COORD_W-1:0];
          CFG_HIGHLIGHT:      hl_idx <= cfg_wdata[INDEX_BITS:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        chord_q.push_back(chord_of(in_tdata[INDEX_BITS-1:0]));
      if (out_tvalid && out_tready) begin
        if (chord_q.size() == 0) begin
          $display("%0t: endpoint transaction with nothing outstanding", $time);
          fail_count++;
        end else begin
          exp_c = chord_q.pop_front();
          if (out_tdata[17:0] !== exp_c.src_x) report_mismatch("src_x", out_tdata[17:0], exp_c.src_x);
          if (out_tdata[35:18] !== exp_c.src_y) report_mismatch("src_y", out_tdata[35:18], exp_c.src_y);
          if (out_tdata[53:36] !== exp_c.dst_x) report_mismatch("dst_x", out_tdata[53:36], exp_c.dst_x);
          if (out_tdata[71:54] !== exp_c.dst_y) report_mismatch("dst_y", out_tdata[71:54], exp_c.dst_y);
          if (out_tuser !== exp_c.hl) report_mismatch("is_highlighted", out_tuser, exp_c.hl);
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Chord endpoint generator regression: directed corner indices and register
// extremes, then randomized register settings with random index streams,
// random stalls on both sides and a long output hold-off.
// ----------------------------------------------------------------------------

module tb;
  import ccg_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int   fail_count;
  int   pending;
  logic active;
  logic no_gaps;
  logic hold_req;
  int   idle_cycles;

  modular_chord_endpoint_generator u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_wr_en, .cfg_addr, .cfg_wdata
  );

  ccg_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_wr_en, .cfg_addr, .cfg_wdata,
    .fail_count, .pending, .active
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on transactions
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (active) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("modular_chord_endpoint_generator regression: fail");
        $finish;
      end
    end
  end

  // endpoint receiver
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_index(logic [INDEX_BITS-1:0] idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_DATA_W'(idx);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid = 1'b0;
    wait (pending == 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    cfg_wr_en = 1'b1;
    cfg_addr  = r;
    cfg_wdata = d;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    logic [INDEX_BITS-1:0] hl;
    logic [INDEX_BITS-1:0] corner[8];
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    no_gaps = 1'b0; hold_req = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    corner = '{0, 1, 2, 45, 90, 131072, 262143, 180};

    // defaults, then register extremes and degenerate turns
    foreach (corner[i]) send_index(corner[i]);
    drain();
    write_reg(CFG_HIGHLIGHT, 32'd90);
    write_reg(CFG_MULTIPLIER, 32'd0);
    foreach (corner[i]) send_index(corner[i]);
    drain();
    write_reg(CFG_TURN_PER_POINT, 32'hFFFF_FFFF);
    write_reg(CFG_MULTIPLIER, 32'hFFFF_FFFF);
    write_reg(CFG_RADIUS, 32'd131072);
    write_reg(CFG_CENTER_X, 32'd0);
    write_reg(CFG_CENTER_Y, 32'd131072);
    write_reg(CFG_HIGHLIGHT, 32'h0003_FFFF);
    foreach (corner[i]) send_index(corner[i]);
    drain();
    write_reg(CFG_TURN_PER_POINT, 32'd0);
    write_reg(CFG_CENTER_X, 32'd131072);
    write_reg(CFG_CENTER_Y, 32'd0);
    write_reg(CFG_HIGHLIGHT, 32'hFFFF_FFFF);
    send_index(0);
    send_index(262143);
    send_index(77);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      hl = INDEX_BITS'($urandom_range(0, 15));
      write_reg(CFG_TURN_PER_POINT, ph == 5 ? 32'd1431655765 : $urandom);
      write_reg(CFG_MULTIPLIER, (ph % 2) ? $urandom : $urandom_range(0, 32'h000F_FFFF));
      write_reg(CFG_CENTER_X, ph == 4 ? 32'd131072 : $urandom);
      write_reg(CFG_CENTER_Y, ph == 4 ? 32'd0 : $urandom);
      write_reg(CFG_RADIUS, ph == 5 ? 32'd0 : $urandom);
      write_reg(CFG_HIGHLIGHT, (ph == 3) ? 32'hFFFF_FFFF
                                         : {13'($urandom_range(0, 8191)), 19'(hl)});
      no_gaps = (ph == 2);
      for (int n = 0; n < 170; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        if (ph == 4 && n == 85) begin
          in_tvalid = 1'b0;
          wait (pending == 0);
          @(negedge clk);
        end
        send_index(($urandom_range(0, 3) == 0) ? INDEX_BITS'($urandom_range(0, 15))
                                                : INDEX_BITS'($urandom));
      end
      no_gaps = 1'b0;
      drain();
    end

    if (fail_count == 0)
      $display("modular_chord_endpoint_generator regression: pass");
    else
      $display("modular_chord_endpoint_generator regression: fail");
    $finish;
  end

endmodule
